### src/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

    localparam int MAX_LINES       = 1024;
    localparam int VERTS_PER_LINE  = 2;
    localparam int STORE_SIZE      = MAX_LINES * VERTS_PER_LINE;
    localparam int MAX_EXTENTS_DEF = 16;

    localparam int LINES_W  = 11;
    localparam int START_W  = 11;
    localparam int LEN_W    = 12;
    localparam int STATUS_W = 2;

    localparam logic [LEN_W-1:0] STORE_LEN = LEN_W'(STORE_SIZE);

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_NO_FIT = 2'd1;
    localparam status_t STATUS_FULL   = 2'd2;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } extent_t;

endpackage

`default_nettype wire

### src/ffba_if.sv
`default_nettype none

interface ffba_req_if;
    import ffba_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [LINES_W-1:0] line_count;
    logic [START_W-1:0] free_offset;
    logic [LEN_W-1:0]   free_size;

    modport source (output valid, action, line_count, free_offset, free_size, input ready);
    modport sink   (input valid, action, line_count, free_offset, free_size, output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  granted_offset;
    logic [LEN_W-1:0]    granted_size;

    modport source (output valid, status, granted_offset, granted_size, input ready);
    modport sink   (input valid, status, granted_offset, granted_size, output ready);
endinterface

`default_nettype wire

### src/first_fit_block_allocator.sv
// First-fit allocator over a linear vertex store of 2048 vertices.
// req channel: action 0 allocates line_count lines (two vertices each) from
// the first free extent that is long enough; action 1 returns the extent
// free_offset/free_size, which is inserted in offset order and coalesced
// with exactly adjacent free extents.
// rsp channel: one transfer per request with status (ok, no fit, list full)
// and, for a successful allocate, the granted offset and size.
// Free extents sit in a MAX_EXTENTS-entry list memory with one read and one
// write port, walked by a small sequencer. It scans the entries, moves them
// to close or open a gap where needed and then loads the result; a zero-size
// request skips the scan. One request is worked through before the next is
// taken: the sequencer returns to idle only after loading the result.
// req.ready is high only while idle.
// The result sits in an output register; a new request is accepted while it
// waits, and the sequencer holds its next result until rsp is free.
// Reset (rst_n low) leaves a single free extent covering the whole store;
// no clearing pass is needed.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_EXTENTS = ffba_pkg::MAX_EXTENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ffba_req_if.sink          req,
    ffba_rsp_if.source        rsp
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               act_reg, act_next;
    logic [LEN_W-1:0]   need_reg, need_next;
    logic [START_W-1:0] off_reg, off_next;
    logic [LEN_W-1:0]   size_reg, size_next;
    extent_t            prev_reg, prev_next;
    logic               has_prev_reg, has_prev_next;
    extent_t            nxt_reg, nxt_next;
    logic               init_reg, init_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_init_reg, rd_init_next;
    status_t            res_status_reg, res_status_next;
    logic [START_W-1:0] res_off_reg, res_off_next;
    logic [LEN_W-1:0]   res_size_reg, res_size_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [START_W-1:0] out_off_reg, out_off_next;
    logic [LEN_W-1:0]   out_size_reg, out_size_next;

    // list memory
    extent_t            mem [MAX_EXTENTS];
    extent_t            rdata_reg;
    logic               re, we;
    logic [IDX_W-1:0]   raddr, waddr;
    extent_t            wdata;

    extent_t            ent;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W-1:0]   prev_end;
    logic [LEN_W-1:0]   off_end;
    logic [CNT_W-1:0]   pos_m1;
    logic               has_next, join_prev, join_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // entry 0 reads as the whole store until it is first written
    assign ent = rd_init_reg ? extent_t'{start: '0, len: STORE_LEN} : rdata_reg;

    assign limit    = STORE_LEN - LEN_W'(req.free_offset);
    assign prev_end = LEN_W'(prev_reg.start) + prev_reg.len;
    assign off_end  = LEN_W'(off_reg) + size_reg;
    assign pos_m1   = pos_reg - CNT_W'(1);
    assign has_next = pos_reg < count_reg;
    assign join_prev = has_prev_reg && (prev_end == LEN_W'(off_reg));
    assign join_next = has_next && (off_end == LEN_W'(nxt_reg.start));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        act_next        = act_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        nxt_next        = nxt_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_size_next   = out_size_reg;
        re              = 1'b0;
        raddr           = ptr_reg[IDX_W-1:0];
        we              = 1'b0;
        waddr           = rd_idx_reg;
        wdata           = ent;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next      = req.action;
                    need_next     = {req.line_count, 1'b0};
                    off_next      = req.free_offset;
                    size_next     = (req.free_size > limit) ? limit : req.free_size;
                    ptr_next      = '0;
                    has_prev_next = 1'b0;
                    res_off_next  = '0;
                    res_size_next = '0;
                    if (req.action == ACT_ALLOC && req.line_count == '0)
                    begin
                        res_status_next = STATUS_NO_FIT;
                        state_next      = S_RESULT;
                    end
                    else if (req.action == ACT_FREE && req.free_size == '0)
                    begin
                        res_status_next = STATUS_OK;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg[IDX_W-1:0];
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (act_reg == ACT_ALLOC)
                    begin
                        if (ent.len >= need_reg)
                        begin
                            re              = 1'b0;
                            res_status_next = STATUS_OK;
                            res_off_next    = ent.start;
                            res_size_next   = need_reg;
                            pos_next        = CNT_W'(rd_idx_reg);
                            if (ent.len == need_reg)
                            begin
                                // extent used up: close the gap
                                ptr_next   = CNT_W'(rd_idx_reg) + CNT_W'(1);
                                state_next = S_SHIFT_DN;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = rd_idx_reg;
                                wdata = '{start: ent.start + need_reg[START_W-1:0],
                                          len:   ent.len - need_reg};
                                state_next = S_RESULT;
                            end
                        end
                    end
                    else if (ent.start <= off_reg)
                    begin
                        prev_next     = ent;
                        has_prev_next = 1'b1;
                    end
                    else
                    begin
                        re         = 1'b0;
                        nxt_next   = ent;
                        pos_next   = CNT_W'(rd_idx_reg);
                        state_next = S_DECIDE;
                    end
                end
                else if (ptr_reg >= count_reg)
                begin
                    if (act_reg == ACT_ALLOC)
                    begin
                        res_status_next = STATUS_NO_FIT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        pos_next   = count_reg;
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                res_status_next = STATUS_OK;
                if (join_prev)
                begin
                    we    = 1'b1;
                    waddr = pos_m1[IDX_W-1:0];
                    wdata = '{start: prev_reg.start,
                              len:   prev_reg.len + size_reg +
                                     (join_next ? nxt_reg.len : '0)};
                    if (join_next)
                    begin
                        ptr_next   = pos_reg + CNT_W'(1);
                        state_next = S_SHIFT_DN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (join_next)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[IDX_W-1:0];
                    wdata      = '{start: off_reg, len: nxt_reg.len + size_reg};
                    state_next = S_RESULT;
                end
                else if (count_reg >= CNT_MAX)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_RESULT;
                end
                else
                begin
                    ptr_next   = count_reg;
                    state_next = S_SHIFT_UP;
                end
            end

            S_SHIFT_DN:
            begin
                if (ptr_reg < count_reg)
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg[IDX_W-1:0];
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = rd_idx_reg - IDX_W'(1);
                    wdata = ent;
                end
                else if (ptr_reg >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESULT;
                end
            end

            S_SHIFT_UP:
            begin
                if (ptr_reg > pos_reg)
                begin
                    re       = 1'b1;
                    ptr_next = ptr_reg - CNT_W'(1);
                    raddr    = ptr_next[IDX_W-1:0];
                end
                if (rd_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = rd_idx_reg + IDX_W'(1);
                    wdata = ent;
                end
                else if (ptr_reg <= pos_reg)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[IDX_W-1:0];
                    wdata      = '{start: off_reg, len: size_reg};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    out_size_next   = res_size_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_vld_next  = re;
    assign rd_idx_next  = raddr;
    assign rd_init_next = init_reg && (raddr == '0);
    assign init_next    = init_reg && !(we && waddr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(1);
            ptr_reg        <= '0;
            pos_reg        <= '0;
            act_reg        <= 1'b0;
            need_reg       <= '0;
            off_reg        <= '0;
            size_reg       <= '0;
            prev_reg       <= '0;
            has_prev_reg   <= 1'b0;
            nxt_reg        <= '0;
            init_reg       <= 1'b1;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            rd_init_reg    <= 1'b0;
            res_status_reg <= STATUS_OK;
            res_off_reg    <= '0;
            res_size_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_off_reg    <= '0;
            out_size_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            pos_reg        <= pos_next;
            act_reg        <= act_next;
            need_reg       <= need_next;
            off_reg        <= off_next;
            size_reg       <= size_next;
            prev_reg       <= prev_next;
            has_prev_reg   <= has_prev_next;
            nxt_reg        <= nxt_next;
            init_reg       <= init_next;
            rd_vld_reg     <= rd_vld_next;
            rd_idx_reg     <= rd_idx_next;
            rd_init_reg    <= rd_init_next;
            res_status_reg <= res_status_next;
            res_off_reg    <= res_off_next;
            res_size_reg   <= res_size_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_off_reg    <= out_off_next;
            out_size_reg   <= out_size_next;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_offset = out_off_reg;
    assign rsp.granted_size   = out_size_reg;

endmodule

`default_nettype wire

### src/ffba_checker.sv
`default_nettype none

module ffba_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [ffba_pkg::STATUS_W-1:0] rsp_status,
    input  logic [ffba_pkg::START_W-1:0]  rsp_offset,
    input  logic [ffba_pkg::LEN_W-1:0]    rsp_size
);
    import ffba_pkg::*;

    localparam int SUM_W = LEN_W + 1;

    // a result held under backpressure keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_offset) && $stable(rsp_size))
        else $error("rsp changed while stalled");

    // one request at a time: busy right after a transfer in
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while busy");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STATUS_OK |-> rsp_offset == '0 && rsp_size == '0)
        else $error("grant reported on failure");

    a_grant_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_OK
            |-> (SUM_W'(rsp_offset) + SUM_W'(rsp_size)) <= SUM_W'(STORE_SIZE))
        else $error("grant runs past the store end");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_offset (rsp.granted_offset),
    .rsp_size   (rsp.granted_size)
);

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int N_EXTENTS    = MAX_EXTENTS_DEF;
    localparam int RANDOM_ITEMS = 1375;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLDOFF_AT   = 3000;
    localparam int HOLDOFF_LEN  = 600;

    typedef struct {
        action_t act;
        int      lines;
        int      off;
        int      size;
        bit      owned;     // free of a block this bench holds
    } request_t;

    typedef struct {
        status_t            status;
        logic [START_W-1:0] off;
        logic [LEN_W-1:0]   size;
    } grant_t;

    typedef struct {
        int start;
        int len;
    } block_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ffba_req_if req();
    ffba_rsp_if rsp();

    first_fit_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // free-list shadow
    logic [START_W-1:0] ext_start [N_EXTENTS];
    logic [LEN_W-1:0]   ext_len   [N_EXTENTS];
    int                 ext_used;

    request_t request_queue [$];
    grant_t   pending_grants [$];
    block_t   held_blocks [$];
    request_t on_bus;
    grant_t   got;
    grant_t   want;
    grant_t   pred;

    int issued_cnt = 0;
    int accepted_cnt = 0;
    int resp_cnt = 0;
    int mismatch_cnt = 0;
    int grant_cnt = 0;
    int free_ok_cnt = 0;
    int no_fit_cnt = 0;
    int full_cnt = 0;
    int cycle_cnt = 0;
    int burst_left;
    int gap_left;
    int rx_phase;
    rx_mode_t rx_mode;
    logic rx_ready_next;
    int unsigned holdoff_timer;
    int holdoff_left;

    function automatic void drop_extent(int i);
        int k;
        for (k = i; k + 1 < ext_used; k++)
        begin
            ext_start[k] = ext_start[k + 1];
            ext_len[k]   = ext_len[k + 1];
        end
        ext_used--;
    endfunction

    function automatic grant_t apply_request(request_t r);
        grant_t g;
        block_t b;
        int need, pos, off, size, k;
        bit prev_adj, next_adj;
        g.status = STATUS_OK;
        g.off    = '0;
        g.size   = '0;
        if (r.act == ACT_ALLOC)
        begin
            need = r.lines * VERTS_PER_LINE;
            g.status = STATUS_NO_FIT;
            if (need != 0)
            begin
                pos = 0;
                while (pos < ext_used && ext_len[pos] < need)
                    pos++;
                if (pos < ext_used)
                begin
                    g.status = STATUS_OK;
                    g.off    = ext_start[pos];
                    g.size   = LEN_W'(need);
                    b.start  = ext_start[pos];
                    b.len    = need;
                    held_blocks = {held_blocks, b};
                    ext_start[pos] = START_W'(ext_start[pos] + need);
                    ext_len[pos]   = LEN_W'(ext_len[pos] - need);
                    if (ext_len[pos] == 0)
                        drop_extent(pos);
                end
            end
        end
        else
        begin
            off  = r.off;
            size = r.size;
            if (size != 0 && off < STORE_SIZE)
            begin
                if (size > STORE_SIZE - off)
                    size = STORE_SIZE - off;
                pos = 0;
                while (pos < ext_used && ext_start[pos] <= off)
                    pos++;
                prev_adj = pos > 0 && (ext_start[pos - 1] + ext_len[pos - 1] == off);
                next_adj = pos < ext_used && (off + size == ext_start[pos]);
                if (prev_adj)
                begin
                    ext_len[pos - 1] = LEN_W'(ext_len[pos - 1] + size);
                    if (next_adj)
                    begin
                        ext_len[pos - 1] = LEN_W'(ext_len[pos - 1] + ext_len[pos]);
                        drop_extent(pos);
                    end
                end
                else if (next_adj)
                begin
                    ext_start[pos] = START_W'(off);
                    ext_len[pos]   = LEN_W'(ext_len[pos] + size);
                end
                else if (ext_used >= N_EXTENTS)
                begin
                    g.status = STATUS_FULL;
                    // block is still ours, try again later
                    if (r.owned)
                    begin
                        b.start = r.off;
                        b.len   = r.size;
                        held_blocks = {held_blocks, b};
                    end
                end
                else
                begin
                    for (k = ext_used; k > pos; k--)
                    begin
                        ext_start[k] = ext_start[k - 1];
                        ext_len[k]   = ext_len[k - 1];
                    end
                    ext_start[pos] = START_W'(off);
                    ext_len[pos]   = LEN_W'(size);
                    ext_used++;
                end
            end
        end
        return g;
    endfunction

    task automatic queue_req(action_t act, int lines, int off, int size, bit owned);
        request_t r;
        r.act   = act;
        r.lines = lines;
        r.off   = off;
        r.size  = size;
        r.owned = owned;
        request_queue = {request_queue, r};
        issued_cnt++;
    endtask

    initial
    begin
        ext_start = '{default: '0};
        ext_len   = '{default: '0};
        ext_len[0] = STORE_LEN;
        ext_used  = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.action      <= 1'b0;
            req.line_count  <= '0;
            req.free_offset <= '0;
            req.free_size   <= '0;
            burst_left      <= 1;
            gap_left        <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
            begin
                pred = apply_request(on_bus);
                pending_grants = {pending_grants, pred};
                accepted_cnt++;
                if (pred.status == STATUS_NO_FIT)
                    no_fit_cnt++;
                else if (pred.status == STATUS_FULL)
                    full_cnt++;
                else if (on_bus.act == ACT_ALLOC)
                    grant_cnt++;
                else
                    free_ok_cnt++;
            end
            if (gap_left != 0 || request_queue.size() == 0)
            begin
                req.valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                on_bus = request_queue.pop_front();
                req.valid       <= 1'b1;
                req.action      <= on_bus.act;
                req.line_count  <= LINES_W'(on_bus.lines);
                req.free_offset <= START_W'(on_bus.off);
                req.free_size   <= LEN_W'(on_bus.size);
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 12);
                    if ($urandom_range(0, 1) == 0)
                        gap_left <= 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left <= 40;
                    else
                        gap_left <= $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_timer <= 0;
            holdoff_left  <= 0;
        end
        else
        begin
            holdoff_timer <= holdoff_timer + 1;
            if (holdoff_timer == HOLDOFF_AT)
                holdoff_left <= HOLDOFF_LEN;
            else if (holdoff_left != 0)
                holdoff_left <= holdoff_left - 1;
        end
    end

    always_comb
    begin
        case (rx_mode)
            RX_ALWAYS:   rx_ready_next = 1'b1;
            RX_MOSTLY:   rx_ready_next = ($urandom_range(0, 3) != 0);
            RX_SPARSE:   rx_ready_next = ($urandom_range(0, 3) == 0);
            default:     rx_ready_next = (rx_phase % 3 == 0);
        endcase
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_phase  <= 0;
            rx_mode   <= RX_ALWAYS;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_mode  <= rx_mode_t'($urandom_range(0, 3));
                rx_phase <= $urandom_range(16, 128);
            end
            else
                rx_phase <= rx_phase - 1;
            rsp.ready <= (holdoff_left == 0) && rx_ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status = rsp.status;
            got.off    = rsp.granted_offset;
            got.size   = rsp.granted_size;
            if (pending_grants.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("response %0d with nothing outstanding: status %0d offset %0d size %0d",
                             resp_cnt, got.status, got.off, got.size);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.status !== want.status || got.off !== want.off ||
                    got.size !== want.size)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("response %0d: status %0d/%0d offset %0d/%0d size %0d/%0d (exp/got)",
                                 resp_cnt, want.status, got.status, want.off, got.off,
                                 want.size, got.size);
                end
            end
            resp_cnt++;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout: %0d of %0d requests taken, %0d responses outstanding",
                     accepted_cnt, issued_cnt, pending_grants.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int k, roll, bias, lines, size, pick, cut;
        block_t blk;

        bias = 50;

        // directed: edge requests, full list, merges, overlap
        queue_req(ACT_ALLOC, 0, 0, 0, 1'b0);
        queue_req(ACT_ALLOC, 2047, 0, 0, 1'b0);
        queue_req(ACT_ALLOC, MAX_LINES, 0, 0, 1'b0);
        queue_req(ACT_ALLOC, 1, 0, 0, 1'b0);
        queue_req(ACT_FREE, 0, 0, 0, 1'b0);
        for (k = 0; k < N_EXTENTS - 1; k++)
            queue_req(ACT_FREE, 0, 128 * k, 4, 1'b0);
        queue_req(ACT_FREE, 0, 2047, 4095, 1'b0);
        queue_req(ACT_FREE, 0, 1000, 8, 1'b0);
        queue_req(ACT_FREE, 0, 4, 124, 1'b0);
        queue_req(ACT_ALLOC, 2, 0, 0, 1'b0);
        queue_req(ACT_FREE, 0, 10, 6, 1'b0);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            while (request_queue.size() >= 2)
                @(posedge clk);
            if (k % 50 == 0)
                bias = $urandom_range(25, 75);
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                // stray free: may overlap free space or run off the end
                cut = $urandom_range(0, 2);
                size = (cut == 0) ? 0 : (cut == 1) ? $urandom_range(1, 32)
                                                   : $urandom_range(1, 4095);
                queue_req(ACT_FREE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          size, 1'b0);
            end
            else if (held_blocks.size() == 0 || $urandom_range(0, 99) < bias)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    lines = $urandom_range(1, 8);
                else if (roll < 88)
                    lines = $urandom_range(9, 64);
                else if (roll < 96)
                    lines = $urandom_range(65, 512);
                else if (roll < 98)
                    lines = MAX_LINES;
                else if (roll == 98)
                    lines = 0;
                else
                    lines = $urandom_range(MAX_LINES + 1, 2047);
                queue_req(ACT_ALLOC, lines, $urandom_range(0, 2047),
                          $urandom_range(0, 4095), 1'b0);
            end
            else
            begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                blk = held_blocks[pick];
                if (blk.len > 1 && $urandom_range(0, 2) == 0)
                begin
                    // return only the front of the block, keep the rest
                    cut = $urandom_range(1, blk.len - 1);
                    held_blocks[pick].start = blk.start + cut;
                    held_blocks[pick].len   = blk.len - cut;
                    blk.len = cut;
                end
                else
                    held_blocks.delete(pick);
                queue_req(ACT_FREE, $urandom_range(0, 2047), blk.start, blk.len, 1'b1);
            end
        end

        while (accepted_cnt != issued_cnt || pending_grants.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests: %0d grants, %0d frees taken, %0d no fit, %0d list full",
                 accepted_cnt, grant_cnt, free_ok_cnt, no_fit_cnt, full_cnt);
        $display("%0d responses checked, %0d mismatches", resp_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### first_fit_block_allocator.f
src/ffba_pkg.sv
src/ffba_if.sv
src/first_fit_block_allocator.sv
src/ffba_checker.sv
tb/tb_top.sv
